// ===== rtl/hds_pkg.sv =====
// Shared constants and types for the hemisphere direction sampler.
`default_nettype none

package hds_pkg;

   // Angles are fractions of a full turn; the residual angle needs sign and headroom
   localparam int ANGLE_W = 34;

   // Converged rotation gain, Q0.32
   localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

   localparam logic [31:0] EIGHTH_TURN = 32'h20000000;

   // Largest magnitude of a Q1.15 result
   localparam int Q15_MAX = 32767;

   // atan(2^-i) in turns, Q0.32, rounded
   localparam logic [31:0] ATAN_TURNS [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   // Quarter turns applied after the fine rotation
   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quadrant_type;

endpackage

`default_nettype wire

// ===== rtl/hemisphere_direction_sampler_core.sv =====
// Top level: uniform hemisphere direction sampler, square-root and CORDIC cell chains.
//
// Each request carries two uniform 16-bit fractions: u_phi picks the azimuth,
// u_cos is the cosine of the polar angle. The response carries the unit
// direction as signed Q1.15 x and y (saturated to +/-32767) and unsigned z.
// The datapath is a row of cells: one squaring stage, FRAC_BITS square-root
// cells (one root bit each), one gain multiply stage, ROTATION_STAGES CORDIC
// cells and an output register.
// Throughput: one request per cycle while the pipe advances; every cell hands its
// item to the next cell each cycle the pipe advances.
// The pipe advances whenever the output register is empty or being drained,
// so req_tready follows rsp_tready while a response is waiting. A stalled
// response holds its data; cells in flight hold in place.
// Reset (synchronous, active high) clears all valid bits; no item is lost
// or produced afterwards. There is no other state to initialize.
`default_nettype none

module hemisphere_direction_sampler_core import hds_pkg::*; #(
   parameter int FRAC_BITS       = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] u_phi, [31:16] u_cos
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // [15:0] dir_x, [31:16] dir_y, [46:32] dir_z, [47] 0
);

   localparam int F       = FRAC_BITS;
   localparam int N       = ROTATION_STAGES;
   localparam int DATA_W  = F + 3;
   localparam int SQ_SIDE = 32;   // pole, dir_z, u_phi
   localparam int CR_SIDE = 17;   // quadrant, dir_z
   localparam int CUP     = (F >= 16) ? F - 16 : 0;
   localparam int CDN     = (F < 16) ? 16 - F : 0;
   localparam int RW      = DATA_W + 17;
   localparam int SH      = (F >= 15) ? F - 15 : 0;
   localparam int UP      = (F < 15) ? 15 - F : 0;
   localparam int HALF    = (SH > 0) ? (1 << (SH - 1)) : 0;
   localparam logic signed [RW-1:0] HALF_R = RW'(HALF);
   localparam logic signed [RW-1:0] SAT_HI = RW'(Q15_MAX);
   localparam logic signed [RW-1:0] SAT_LO = -SAT_HI;

   logic en;

   // Input stage: cosine to F fraction bits, then square it
   logic [15:0]    u_phi;
   logic [15:0]    u_cos;
   logic [F+15:0]  c_wide;
   logic [F-1:0]   c_val;
   logic           s0_valid_ff;
   logic [2*F-1:0] s0_sq_ff;
   logic           s0_pole_ff;
   logic [15:0]    s0_phi_ff;
   logic [14:0]    s0_dirz_ff;

   assign u_phi  = req_tdata[15:0];
   assign u_cos  = req_tdata[31:16];
   assign c_wide = ({{F{1'b0}}, u_cos} << CUP) >> CDN;
   assign c_val  = c_wide[F-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_sq_ff   <= c_val * c_val;
         s0_pole_ff <= (c_val == '0);
         s0_phi_ff  <= u_phi;
         s0_dirz_ff <= u_cos[15:1];
      end
   end

   // Square-root chain on 2^2F - c^2 (two's complement negation in 2F bits)
   logic                 sq_vld  [F+1];
   logic [2*F-1:0]       sq_rad  [F+1];
   logic [F:0]           sq_rem  [F+1];
   logic [F-1:0]         sq_root [F+1];
   logic [SQ_SIDE-1:0]   sq_side [F+1];

   assign sq_vld[0]  = s0_valid_ff;
   assign sq_rad[0]  = '0 - s0_sq_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = {s0_pole_ff, s0_dirz_ff, s0_phi_ff};

   for (genvar i = 0; i < F; i++) begin : g_sqrt
      hds_sqrt_cell #(
         .FRAC_BITS (F),
         .SIDE_W    (SQ_SIDE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_vld[i]),
         .in_rad    (sq_rad[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_vld[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // Gain stage: start vector x0 = s*K/2^32, residual angle and quadrant
   logic                      pole;
   logic [F:0]                s_val;
   logic [F+32:0]             gain_prod;
   logic [31:0]               turn;
   logic signed [ANGLE_W-1:0] z_start;
   logic                      g_valid_ff;
   logic signed [DATA_W-1:0]  g_x_ff;
   logic signed [ANGLE_W-1:0] g_z_ff;
   logic [CR_SIDE-1:0]        g_side_ff;

   assign pole      = sq_side[F][31];
   assign s_val     = pole ? ((F+1)'(1) << F) : {1'b0, sq_root[F]};
   assign gain_prod = s_val * GAIN_Q32;
   assign turn      = {sq_side[F][15:0], 16'h0000} + EIGHTH_TURN;
   assign z_start   = signed'({{(ANGLE_W-30){1'b0}}, turn[29:0]})
                      - signed'(ANGLE_W'(EIGHTH_TURN));

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (en) begin
         g_valid_ff <= sq_vld[F];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_x_ff    <= signed'({2'b00, gain_prod[F+32:32]});
         g_z_ff    <= z_start;
         g_side_ff <= {turn[31:30], sq_side[F][30:16]};
      end
   end

   // CORDIC chain
   logic                      cr_vld  [N+1];
   logic signed [DATA_W-1:0]  cr_x    [N+1];
   logic signed [DATA_W-1:0]  cr_y    [N+1];
   logic signed [ANGLE_W-1:0] cr_z    [N+1];
   logic [CR_SIDE-1:0]        cr_side [N+1];

   assign cr_vld[0]  = g_valid_ff;
   assign cr_x[0]    = g_x_ff;
   assign cr_y[0]    = '0;
   assign cr_z[0]    = g_z_ff;
   assign cr_side[0] = g_side_ff;

   for (genvar i = 0; i < N; i++) begin : g_cordic
      hds_cordic_cell #(
         .DATA_W    (DATA_W),
         .STAGE     (i),
         .SIDE_W    (CR_SIDE)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cr_vld[i]),
         .in_x      (cr_x[i]),
         .in_y      (cr_y[i]),
         .in_z      (cr_z[i]),
         .in_side   (cr_side[i]),
         .out_valid (cr_vld[i+1]),
         .out_x     (cr_x[i+1]),
         .out_y     (cr_y[i+1]),
         .out_z     (cr_z[i+1]),
         .out_side  (cr_side[i+1])
      );
   end

   // Round to Q1.15 and saturate
   function automatic logic [15:0] to_q15(input logic signed [DATA_W-1:0] v);
      logic signed [RW-1:0] r;
      r = ((RW'(v) + HALF_R) >>> SH) <<< UP;
      if (r > SAT_HI) begin
         r = SAT_HI;
      end else if (r < SAT_LO) begin
         r = SAT_LO;
      end
      return r[15:0];
   endfunction

   // Quarter-turn rotation of the finished vector
   quadrant_type             quad;
   logic signed [DATA_W-1:0] rot_x;
   logic signed [DATA_W-1:0] rot_y;

   assign quad = quadrant_type'(cr_side[N][16:15]);

   always_comb begin
      unique case (quad)
         QUAD_90: begin
            rot_x = -cr_y[N];
            rot_y = cr_x[N];
         end
         QUAD_180: begin
            rot_x = -cr_x[N];
            rot_y = -cr_y[N];
         end
         QUAD_270: begin
            rot_x = cr_y[N];
            rot_y = -cr_x[N];
         end
         default: begin
            rot_x = cr_x[N];
            rot_y = cr_y[N];
         end
      endcase
   end

   // Output register; the whole pipe advances when it is free or being drained
   logic        out_valid_ff;
   logic [15:0] out_x_ff;
   logic [15:0] out_y_ff;
   logic [14:0] out_z_ff;

   assign en = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= cr_vld[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff <= to_q15(rot_x);
         out_y_ff <= to_q15(rot_y);
         out_z_ff <= cr_side[N][14:0];
      end
   end

   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_z_ff, out_y_ff, out_x_ff};

endmodule

`default_nettype wire

// ===== rtl/hds_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root (one root bit per cell).
`default_nettype none

module hds_sqrt_cell #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W    = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic [2*FRAC_BITS-1:0]   in_rad,
   input  wire logic [FRAC_BITS:0]       in_rem,
   input  wire logic [FRAC_BITS-1:0]     in_root,
   input  wire logic [SIDE_W-1:0]        in_side,
   output logic                          out_valid,
   output logic [2*FRAC_BITS-1:0]        out_rad,
   output logic [FRAC_BITS:0]            out_rem,
   output logic [FRAC_BITS-1:0]          out_root,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int F = FRAC_BITS;

   logic              valid_ff;
   logic [2*F-1:0]    rad_ff, rad_in;
   logic [F:0]        rem_ff, rem_in;
   logic [F-1:0]      root_ff, root_in;
   logic [SIDE_W-1:0] side_ff;
   logic [F+1:0]      shifted;
   logic [F+1:0]      trial;
   logic [F+1:0]      diff;

   // Bring down the next two radicand bits and try the next root bit
   always_comb begin
      shifted = {in_rem[F-1:0], in_rad[2*F-1:2*F-2]};
      trial   = {in_root, 2'b01};
      diff    = shifted - trial;
      rad_in  = {in_rad[2*F-3:0], 2'b00};
      if (shifted >= trial) begin
         rem_in  = diff[F:0];
         root_in = {in_root[F-2:0], 1'b1};
      end else begin
         rem_in  = shifted[F:0];
         root_in = {in_root[F-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== rtl/hds_cordic_cell.sv =====
// One rotation cell of the CORDIC chain: a fixed shift and arctangent per cell.
`default_nettype none

module hds_cordic_cell import hds_pkg::*; #(
   parameter int DATA_W = 19,
   parameter int STAGE  = 0,
   parameter int SIDE_W = 17
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      en,
   input  wire logic                      in_valid,
   input  wire logic signed [DATA_W-1:0]  in_x,
   input  wire logic signed [DATA_W-1:0]  in_y,
   input  wire logic signed [ANGLE_W-1:0] in_z,
   input  wire logic [SIDE_W-1:0]         in_side,
   output logic                           out_valid,
   output logic signed [DATA_W-1:0]       out_x,
   output logic signed [DATA_W-1:0]       out_y,
   output logic signed [ANGLE_W-1:0]      out_z,
   output logic [SIDE_W-1:0]              out_side
);

   localparam logic signed [ANGLE_W-1:0] ATAN_STEP =
      signed'({{(ANGLE_W-32){1'b0}}, ATAN_TURNS[STAGE]});

   logic                      valid_ff;
   logic signed [DATA_W-1:0]  x_ff, x_in;
   logic signed [DATA_W-1:0]  y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;
   logic [SIDE_W-1:0]         side_ff;
   logic signed [DATA_W-1:0]  dx;
   logic signed [DATA_W-1:0]  dy;

   // Micro-rotation toward zero residual angle; shifts floor toward minus infinity
   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (!in_z[ANGLE_W-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN_STEP;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for the hemisphere direction sampler: stream driver, predictor, monitor.
module testbench import hds_pkg::*;;

   localparam int FRAC_BITS       = 16;
   localparam int ROTATION_STAGES = 16;
   localparam int PIPE_DEPTH      = FRAC_BITS + ROTATION_STAGES + 3;
   localparam int RANDOM_DRAWS    = 1900;
   localparam int LONG_HOLD       = 300;

   // Rotation constants kept locally so a bad package table cannot hide itself
   localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;
   localparam logic [31:0] TURN_EIGHTH = 32'h20000000;
   localparam longint      SAT_LIMIT   = 32767;

   localparam logic [31:0] ATAN_TURN_TBL [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic [15:0] u_phi;
      logic [15:0] u_cos;
      logic        drain;   // wait for an empty pipe before offering this request
   } draw_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic [14:0]        dir_z;
   } dir_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = 32'h0;   // [15:0] u_phi, [31:16] u_cos
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;            // [15:0] dir_x, [31:16] dir_y, [46:32] dir_z, [47] 0

   draw_type draw_queue [$];
   dir_type  pending_dirs [$];

   int  accepted_draws = 0;
   int  results_seen   = 0;
   int  mismatches     = 0;
   int  send_gap       = 0;
   int  recv_gap       = 0;
   int  recv_cycles    = 0;
   bit  send_calm      = 1'b0;
   bit  recv_calm      = 1'b0;
   bit  long_hold_done = 1'b0;
   bit  tail_phase     = 1'b0;

   hemisphere_direction_sampler_core #(
      .FRAC_BITS       (FRAC_BITS),
      .ROTATION_STAGES (ROTATION_STAGES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Bit-serial floor square root
   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bit_w;
      rem   = v;
      res   = 0;
      bit_w = 64'h4000_0000_0000_0000;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Round half up to Q1.15 and clamp symmetric
   function automatic logic [15:0] to_q1_15(input longint v);
      longint r;
      longint half;
      int     sh;
      if (FRAC_BITS >= 15) begin
         sh   = FRAC_BITS - 15;
         half = (sh > 0) ? (longint'(1) <<< (sh - 1)) : longint'(0);
         r    = (v + half) >>> sh;
      end else begin
         r = v * (longint'(1) <<< (15 - FRAC_BITS));
      end
      if (r > SAT_LIMIT) r = SAT_LIMIT;
      if (r < -SAT_LIMIT) r = -SAT_LIMIT;
      return r[15:0];
   endfunction

   // Expected direction for one pair of uniform draws
   function automatic dir_type sample_direction(input logic [15:0] u_phi,
                                                input logic [15:0] u_cos);
      longint unsigned one_w;
      longint unsigned cos_w;
      longint unsigned sin_w;
      logic [31:0]     turn;
      quadrant_type    quad;
      longint          ang;
      longint          vx;
      longint          vy;
      longint          dx;
      longint          dy;
      longint          tmp;
      dir_type         d;
      one_w = longint'(1) << FRAC_BITS;
      if (FRAC_BITS >= 16) cos_w = 64'(u_cos) << (FRAC_BITS - 16);
      else cos_w = 64'(u_cos) >> (16 - FRAC_BITS);
      // the pole gives exactly one, no root taken
      if (cos_w == 0) sin_w = one_w;
      else sin_w = root_floor((one_w - cos_w) * (one_w + cos_w));

      // nearest quarter turn plus residual in [-1/8, 1/8)
      turn = {u_phi, 16'h0000} + TURN_EIGHTH;
      quad = quadrant_type'(turn[31:30]);
      ang  = longint'(turn[29:0]) - longint'(TURN_EIGHTH);

      vx = longint'((sin_w * 64'(CORDIC_GAIN)) >> 32);
      vy = 0;
      for (int i = 0; i < ROTATION_STAGES; i++) begin
         dx = vy >>> (i & 31);
         dy = vx >>> (i & 31);
         if (ang >= 0) begin
            vx  = vx - dx;
            vy  = vy + dy;
            ang = ang - longint'(ATAN_TURN_TBL[i & 31]);
         end else begin
            vx  = vx + dx;
            vy  = vy - dy;
            ang = ang + longint'(ATAN_TURN_TBL[i & 31]);
         end
      end

      case (quad)
         QUAD_90: begin
            tmp = vx;
            vx  = -vy;
            vy  = tmp;
         end
         QUAD_180: begin
            vx = -vx;
            vy = -vy;
         end
         QUAD_270: begin
            tmp = vx;
            vx  = vy;
            vy  = -tmp;
         end
         default: ;
      endcase

      d.dir_x = to_q1_15(vx);
      d.dir_y = to_q1_15(vy);
      d.dir_z = u_cos[15:1];
      return d;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int idle_len(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Uniform field, with corner values mixed in
   function automatic logic [15:0] draw_field();
      logic [15:0] corners [10];
      corners = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF,
                  16'h4000, 16'hC000, 16'h2000, 16'h1FFF, 16'hE000};
      if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 9)];
      return 16'($urandom_range(0, 65535));
   endfunction

   // Request driver
   always @(posedge clock) begin : drive
      logic        valid_n;
      logic [31:0] data_n;
      draw_type    item;
      valid_n = req_tvalid;
      data_n  = req_tdata;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_dirs.push_back(sample_direction(req_tdata[15:0], req_tdata[31:16]));
            accepted_draws++;
            if (accepted_draws % 150 == 0) send_calm = ($urandom_range(0, 2) == 0);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               valid_n = 1'b0;
            end else if (draw_queue.size() == 0) begin
               valid_n = 1'b0;
            end else if (draw_queue[0].drain && pending_dirs.size() != 0) begin
               valid_n = 1'b0;
            end else begin
               item     = draw_queue.pop_front();
               data_n   = {item.u_cos, item.u_phi};
               valid_n  = 1'b1;
               send_gap = idle_len(send_calm);
            end
         end
         req_tvalid <= valid_n;
         req_tdata  <= data_n;
      end
   end

   // Response back-pressure, with one long hold once traffic is flowing
   always @(posedge clock) begin : backpressure
      logic ready_n;
      int   g;
      ready_n = 1'b0;
      if (!reset) begin
         recv_cycles++;
         if (recv_cycles % 256 == 0) recv_calm = ($urandom_range(0, 2) == 0);
         if (tail_phase) begin
            ready_n = 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
         end else if (!long_hold_done && results_seen >= 200) begin
            long_hold_done = 1'b1;
            recv_gap       = LONG_HOLD - 1;
         end else begin
            g = idle_len(recv_calm);
            if (g == 0) ready_n = 1'b1;
            else recv_gap = g - 1;
         end
      end
      rsp_tready <= ready_n;
   end

   // Response monitor
   always @(posedge clock) begin : monitor
      dir_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (pending_dirs.size() == 0) begin
            $display("%0t unexpected response: expected none, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_dirs.pop_front();
            if (rsp_tdata[15:0] !== want.dir_x) begin
               $display("%0t dir_x: expected %0d, got %0d", $time, want.dir_x,
                        $signed(rsp_tdata[15:0]));
               mismatches++;
            end
            if (rsp_tdata[31:16] !== want.dir_y) begin
               $display("%0t dir_y: expected %0d, got %0d", $time, want.dir_y,
                        $signed(rsp_tdata[31:16]));
               mismatches++;
            end
            if (rsp_tdata[46:32] !== want.dir_z) begin
               $display("%0t dir_z: expected %0d, got %0d", $time, want.dir_z,
                        rsp_tdata[46:32]);
               mismatches++;
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [31:0] directed [22];
      draw_type    item;
      // {u_cos, u_phi}: pole, horizon, quadrant and eighth-turn boundaries
      directed = '{
         32'h0000_0000, 32'h0000_4000, 32'h0000_8000, 32'h0000_C000,
         32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0001_FFFF,
         32'h8000_2000, 32'h8000_1FFF, 32'h8000_6000, 32'h8000_5FFF,
         32'h7FFF_A000, 32'h7FFF_9FFF, 32'hAAAA_E000, 32'h5555_DFFF,
         32'h0000_FFFF, 32'hFFFF_8000, 32'h0000_2000, 32'hC000_4000,
         32'h4000_C000, 32'hFFFE_0001
      };
      foreach (directed[i]) begin
         item.u_phi = directed[i][15:0];
         item.u_cos = directed[i][31:16];
         item.drain = 1'b0;
         draw_queue.push_back(item);
      end
      for (int i = 0; i < RANDOM_DRAWS; i++) begin
         item.u_phi = draw_field();
         item.u_cos = draw_field();
         item.drain = (i == 0) || (i == 1000);
         draw_queue.push_back(item);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (draw_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_dirs.size() != 0) @(posedge clock);
      tail_phase <= 1'b1;
      repeat (PIPE_DEPTH + 10) @(posedge clock);

      if (mismatches == 0 && pending_dirs.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin : watchdog
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
